// File: sv/psls_pkg.sv
// Shared types and constants for the per-source link statistics unit.
// Used by the front end, queue, back end and top level; depends on nothing else.
package psls_pkg;

  localparam int unsigned SOURCES_DEFAULT = 256;
  localparam int unsigned RSSI_WINDOW     = 11;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [20:0] ONE_SECOND_US     = 21'd1000000;
  localparam logic [19:0] LATENCY_MIN_RESET = 20'd100000;
  localparam logic [7:0]  OWN_ADDR_RESET    = 8'd0;
  localparam logic [7:0]  BCAST_ADDR_RESET  = 8'd255;

  localparam logic [1:0] CFG_OWN_ADDRESS       = 2'd0;
  localparam logic [1:0] CFG_BROADCAST_ADDRESS = 2'd1;

  typedef enum logic [1:0] {
    REQ_FRAME    = 2'd0,
    REQ_READ     = 2'd1,
    REQ_CLEAR    = 2'd2,
    REQ_RESERVED = 2'd3
  } req_e;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_FETCH = 2'd1,
    OP_WIPE  = 2'd2
  } op_e;

  typedef struct packed {
    logic [31:0] recv_count;
    logic [31:0] lost_count;
    logic [47:0] latency_total;
    logic [31:0] latency_count;
    logic [19:0] latency_peak;
    logic [19:0] latency_floor;
    logic [7:0]  last_seq;
    logic [11:0] rssi_total;
    logic [3:0]  rssi_count;
  } rec_t;

  localparam rec_t REC_RESET = '{
    recv_count:    32'd0,
    lost_count:    32'd0,
    latency_total: 48'd0,
    latency_count: 32'd0,
    latency_peak:  20'd0,
    latency_floor: LATENCY_MIN_RESET,
    last_seq:      8'd0,
    rssi_total:    12'd0,
    rssi_count:    4'd0
  };

  typedef struct packed {
    op_e         op;
    logic        in_table;
    logic [7:0]  source;
    logic [7:0]  seq;
    logic [19:0] latency;
    logic [7:0]  rssi;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [19:0] frame_latency;
    logic [7:0]  lost_this_frame;
    rec_t        rec;
  } res_t;

endpackage

// File: sv/psls_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the back end for the statistics records.
module psls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/psls_front.sv
// Front end: configuration registers, address filter and latency calculation.
// Depends on psls_pkg; feeds classified work into psls_queue.
module psls_front #(
  parameter int unsigned SOURCES = psls_pkg::SOURCES_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         dest_address_i,
  input  logic [7:0]         source_address_i,
  input  logic [7:0]         sequence_index_i,
  input  logic [19:0]        send_time_us_i,
  input  logic [19:0]        arrival_time_us_i,
  input  logic [7:0]         rssi_level_i,
  input  logic               q_ready_i,
  output logic               push_o,
  output psls_pkg::item_t    item_o
);

  logic [7:0]  own_address_q, own_address_d;
  logic [7:0]  bcast_address_q, bcast_address_d;
  logic        in_table;
  logic        addr_match;
  logic [20:0] wrapped;
  logic [19:0] latency;

  always_comb begin
    own_address_d   = own_address_q;
    bcast_address_d = bcast_address_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        psls_pkg::CFG_OWN_ADDRESS:       own_address_d   = cfg_data_i;
        psls_pkg::CFG_BROADCAST_ADDRESS: bcast_address_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q   <= psls_pkg::OWN_ADDR_RESET;
      bcast_address_q <= psls_pkg::BCAST_ADDR_RESET;
    end else begin
      own_address_q   <= own_address_d;
      bcast_address_q <= bcast_address_d;
    end
  end

  assign in_table   = {1'b0, source_address_i} < 9'(SOURCES);
  assign addr_match = (dest_address_i == own_address_q) ||
                      (dest_address_i == bcast_address_q);

  // Arrival at or before the send time means the second rolled over.
  assign wrapped = {1'b0, arrival_time_us_i} + psls_pkg::ONE_SECOND_US -
                   {1'b0, send_time_us_i};
  assign latency = (arrival_time_us_i > send_time_us_i) ?
                   (arrival_time_us_i - send_time_us_i) : wrapped[19:0];

  always_comb begin
    item_o.in_table = in_table;
    item_o.source   = source_address_i;
    item_o.seq      = sequence_index_i;
    item_o.latency  = latency;
    item_o.rssi     = rssi_level_i;
    unique case (psls_pkg::req_e'(req_type_i))
      psls_pkg::REQ_CLEAR: item_o.op = psls_pkg::OP_WIPE;
      psls_pkg::REQ_FRAME: begin
        item_o.op = (in_table && addr_match) ? psls_pkg::OP_COUNT : psls_pkg::OP_FETCH;
      end
      default: item_o.op = psls_pkg::OP_FETCH;
    endcase
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

endmodule

// File: sv/psls_queue.sv
// Short FIFO that decouples the front end from the back end.
// Depends on psls_pkg for the work item type and the depth.
module psls_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  psls_pkg::item_t item_i,
  output logic            ready_o,
  output logic            valid_o,
  output psls_pkg::item_t item_o,
  input  logic            pop_i
);

  localparam int unsigned Depth = psls_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;

  psls_pkg::item_t  entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    count_q, count_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready_o = count_q != (PtrW + 1)'(Depth);
  assign valid_o = count_q != '0;
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: sv/psls_back.sv
// Back end: reads one statistics record per request and writes it back for counted frames.
// Depends on psls_pkg and psls_ram; takes work from psls_queue.
module psls_back #(
  parameter int unsigned SOURCES = psls_pkg::SOURCES_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  psls_pkg::item_t q_item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output psls_pkg::res_t  res_o
);

  localparam int unsigned AddrW = $clog2(SOURCES);
  localparam int unsigned RecW  = $bits(psls_pkg::rec_t);

  typedef enum logic {
    S_READ,
    S_UPDATE
  } state_e;

  state_e          state_q;
  psls_pkg::item_t item_q;
  logic [SOURCES-1:0] valid_q;
  logic            out_valid_q;
  psls_pkg::res_t  out_q;

  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] idx;
  logic [RecW-1:0]  rdata;
  psls_pkg::rec_t   cur;
  psls_pkg::rec_t   nxt;
  psls_pkg::res_t   res_d;
  logic             out_free;
  logic             done;
  logic             write_en;
  logic             first;
  logic [7:0]       gap;

  assign raddr = q_item_i.source[AddrW-1:0];
  assign idx   = item_q.source[AddrW-1:0];
  assign pop_o = (state_q == S_READ) && q_valid_i;

  psls_ram #(
    .WIDTH(RecW),
    .DEPTH(SOURCES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (write_en),
    .waddr_i(idx),
    .wdata_i(nxt),
    .re_i   (pop_o),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // A record not written since reset or the last clear reads as the reset record.
  assign cur = valid_q[idx] ? psls_pkg::rec_t'(rdata) : psls_pkg::REC_RESET;

  assign first = cur.recv_count == 32'd0;
  // seq - last - 1 modulo 256 covers both the forward gap and the wrapped case.
  assign gap   = first ? 8'd0 : (item_q.seq - cur.last_seq - 8'd1);

  always_comb begin
    nxt = cur;
    unique case (item_q.op)
      psls_pkg::OP_COUNT: begin
        nxt.recv_count    = cur.recv_count + 32'd1;
        nxt.lost_count    = cur.lost_count + 32'(gap);
        nxt.latency_total = cur.latency_total + 48'(item_q.latency);
        nxt.latency_count = cur.latency_count + 32'd1;
        if (item_q.latency > cur.latency_peak) begin
          nxt.latency_peak = item_q.latency;
        end
        if (item_q.latency < cur.latency_floor) begin
          nxt.latency_floor = item_q.latency;
        end
        nxt.last_seq = item_q.seq;
        if (cur.rssi_count >= 4'(psls_pkg::RSSI_WINDOW)) begin
          nxt.rssi_total = 12'(item_q.rssi);
          nxt.rssi_count = 4'd1;
        end else begin
          nxt.rssi_total = cur.rssi_total + 12'(item_q.rssi);
          nxt.rssi_count = cur.rssi_count + 4'd1;
        end
      end
      psls_pkg::OP_WIPE: nxt = psls_pkg::REC_RESET;
      default: nxt = cur;
    endcase
  end

  always_comb begin
    res_d.accepted        = item_q.op == psls_pkg::OP_COUNT;
    res_d.frame_latency   = res_d.accepted ? item_q.latency : 20'd0;
    res_d.lost_this_frame = res_d.accepted ? gap : 8'd0;
    res_d.rec             = item_q.in_table ? nxt : '0;
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign done     = (state_q == S_UPDATE) && out_free;
  assign write_en = done && (item_q.op == psls_pkg::OP_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_READ;
      item_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      unique case (state_q)
        S_READ: begin
          if (pop_o) begin
            item_q  <= q_item_i;
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (done) begin
            out_q   <= res_d;
            state_q <= S_READ;
            if (item_q.op == psls_pkg::OP_WIPE) begin
              valid_q <= '0;
            end else if (item_q.op == psls_pkg::OP_COUNT) begin
              valid_q[idx] <= 1'b1;
            end
          end
        end
        default: state_q <= S_READ;
      endcase
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// File: sv/per_source_link_statistics_unit.sv
// Per-source link statistics unit: one statistics record per frame source.
// A request passes through the queue, then the back end's read and update states,
// which load the result register; the back end takes no new request until it is
// through with the last one, and waits while the held result is not yet taken.
// Reset: records are cleared at once through per-entry valid bits, with no
// clearing pass; own address resets to 0 and broadcast address to 255.
module per_source_link_statistics_unit #(
  parameter int unsigned SOURCES = psls_pkg::SOURCES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // Request channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  dest_address_i,
  input  logic [7:0]  source_address_i,
  input  logic [7:0]  sequence_index_i,
  input  logic [19:0] send_time_us_i,
  input  logic [19:0] arrival_time_us_i,
  input  logic [7:0]  rssi_level_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [19:0] frame_latency_o,
  output logic [7:0]  lost_this_frame_o,
  output logic [31:0] received_count_o,
  output logic [31:0] lost_count_o,
  output logic [47:0] latency_total_o,
  output logic [31:0] latency_count_o,
  output logic [19:0] latency_peak_o,
  output logic [19:0] latency_floor_o,
  output logic [11:0] rssi_total_o,
  output logic [3:0]  rssi_count_o
);

  // The front end classifies each request in the cycle it arrives: it applies
  // the address filter, works out the frame latency with the one-second wrap
  // and turns the request code into a count, fetch or wipe operation.
  psls_pkg::item_t push_item;
  psls_pkg::item_t q_item;
  logic            push;
  logic            q_ready;
  logic            q_valid;
  logic            pop;
  psls_pkg::res_t  res;

  psls_front #(
    .SOURCES(SOURCES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .dest_address_i   (dest_address_i),
    .source_address_i (source_address_i),
    .sequence_index_i (sequence_index_i),
    .send_time_us_i   (send_time_us_i),
    .arrival_time_us_i(arrival_time_us_i),
    .rssi_level_i     (rssi_level_i),
    .q_ready_i        (q_ready),
    .push_o           (push),
    .item_o           (push_item)
  );

  // The queue lets the front keep taking requests while the back end is busy
  // or its result is held by a stalled consumer.
  psls_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .item_o (q_item),
    .pop_i  (pop)
  );

  // The back end reads the record and updates it; a counted frame is written back
  // as the result register is loaded. A clear only drops every valid bit.
  psls_back #(
    .SOURCES(SOURCES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign accepted_o        = res.accepted;
  assign frame_latency_o   = res.frame_latency;
  assign lost_this_frame_o = res.lost_this_frame;
  assign received_count_o  = res.rec.recv_count;
  assign lost_count_o      = res.rec.lost_count;
  assign latency_total_o   = res.rec.latency_total;
  assign latency_count_o   = res.rec.latency_count;
  assign latency_peak_o    = res.rec.latency_peak;
  assign latency_floor_o   = res.rec.latency_floor;
  assign rssi_total_o      = res.rec.rssi_total;
  assign rssi_count_o      = res.rec.rssi_count;

endmodule

// File: verif/tb_per_source_link_statistics_unit.sv
// Self-checking testbench for the per-source link statistics unit.
// Depends on psls_pkg and per_source_link_statistics_unit; needs nothing else.
module tb_per_source_link_statistics_unit;

  // The block is built with its full table, so every source address has a record.
  localparam int unsigned NUM_SOURCES       = 256;
  localparam int unsigned WINDOW_SAMPLES    = 11;
  localparam logic [31:0] US_PER_SECOND     = 32'd1000000;
  localparam logic [19:0] FLOOR_AFTER_CLEAR = 20'd100000;
  localparam int unsigned PHASE_REQUESTS    = 310;
  localparam int unsigned HOLD_OFF_CYCLES   = 300;

  // One result of the block: the per-frame fields followed by the record.
  typedef struct packed {
    logic        acc;
    logic [19:0] lat;
    logic [7:0]  lost;
    logic [31:0] rcv;
    logic [31:0] lcnt;
    logic [47:0] ltot;
    logic [31:0] lnum;
    logic [19:0] lpeak;
    logic [19:0] lfloor;
    logic [11:0] rtot;
    logic [3:0]  rnum;
  } link_report_t;

  // One request as offered to the block. Where fixed is set, want holds the
  // result that is read straight off the specification and replaces the
  // prediction for that request.
  typedef struct {
    psls_pkg::req_e kind;
    logic [7:0]     dest;
    logic [7:0]     src;
    logic [7:0]     seq;
    logic [19:0]    sent;
    logic [19:0]    arrived;
    logic [7:0]     rssi;
    bit             fixed;
    link_report_t   want;
  } stat_request_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_we_i          = 1'b0;
  logic [1:0]  cfg_index_i       = psls_pkg::CFG_OWN_ADDRESS;
  logic [7:0]  cfg_data_i        = 8'd0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i        = psls_pkg::REQ_FRAME;
  logic [7:0]  dest_address_i    = 8'd0;
  logic [7:0]  source_address_i  = 8'd0;
  logic [7:0]  sequence_index_i  = 8'd0;
  logic [19:0] send_time_us_i    = 20'd0;
  logic [19:0] arrival_time_us_i = 20'd0;
  logic [7:0]  rssi_level_i      = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic        accepted_o;
  logic [19:0] frame_latency_o;
  logic [7:0]  lost_this_frame_o;
  logic [31:0] received_count_o;
  logic [31:0] lost_count_o;
  logic [47:0] latency_total_o;
  logic [31:0] latency_count_o;
  logic [19:0] latency_peak_o;
  logic [19:0] latency_floor_o;
  logic [11:0] rssi_total_o;
  logic [3:0]  rssi_count_o;

  // Our own copy of the statistics table and the address filter.
  logic [31:0] frames_seen     [NUM_SOURCES];
  logic [31:0] missed_frames   [NUM_SOURCES];
  logic [47:0] latency_acc     [NUM_SOURCES];
  logic [31:0] latency_n       [NUM_SOURCES];
  logic [19:0] latency_high    [NUM_SOURCES];
  logic [19:0] latency_low     [NUM_SOURCES];
  logic [7:0]  previous_seq    [NUM_SOURCES];
  logic [11:0] rssi_acc        [NUM_SOURCES];
  logic [3:0]  rssi_n          [NUM_SOURCES];
  logic [7:0]  own_filter;
  logic [7:0]  bcast_filter;

  // Results still owed by the block, oldest first.
  link_report_t  pending_reports[$];
  int unsigned   mismatches = 0;

  // Side information travelling with the request currently offered.
  bit            offer_fixed = 1'b0;
  link_report_t  offer_want  = '0;

  // Sequence number the stimulus would send next for each source, so that most
  // frames arrive in order and the loss counters see realistic gaps.
  bit [7:0]      next_seq [NUM_SOURCES];

  // Set by the stimulus to make the result side refuse results for a long while.
  bit            hold_off_req = 1'b0;

  per_source_link_statistics_unit dut (.*);

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void wipe_records();
    for (int i = 0; i < NUM_SOURCES; i++) begin
      frames_seen[i]   = 32'd0;
      missed_frames[i] = 32'd0;
      latency_acc[i]   = 48'd0;
      latency_n[i]     = 32'd0;
      latency_high[i]  = 20'd0;
      latency_low[i]   = FLOOR_AFTER_CLEAR;
      previous_seq[i]  = 8'd0;
      rssi_acc[i]      = 12'd0;
      rssi_n[i]        = 4'd0;
    end
  endfunction

  // Applies one request to the table copy and returns the result it causes.
  function automatic link_report_t apply_request(psls_pkg::req_e kind, logic [7:0] dest,
                                                 logic [7:0] src, logic [7:0] seq,
                                                 logic [19:0] sent,
                                                 logic [19:0] arrived,
                                                 logic [7:0] rssi);
    link_report_t r;
    logic [31:0]  span;
    logic [7:0]   gap;
    bit           first;
    bit           in_table;
    r        = '0;
    in_table = (int'(src) < NUM_SOURCES);
    if (kind == psls_pkg::REQ_CLEAR) begin
      wipe_records();
    end else if (kind == psls_pkg::REQ_FRAME && in_table &&
                 (dest == bcast_filter || dest == own_filter)) begin
      first = (frames_seen[src] == 32'd0);
      r.acc = 1'b1;
      frames_seen[src] = frames_seen[src] + 32'd1;

      // Latency wraps at one second; equal times therefore count a full second.
      if (arrived > sent) begin
        span = {12'd0, arrived} - {12'd0, sent};
      end else begin
        span = {12'd0, arrived} + US_PER_SECOND - {12'd0, sent};
      end
      r.lat = span[19:0];
      latency_acc[src] = latency_acc[src] + {28'd0, r.lat};
      latency_n[src]   = latency_n[src] + 32'd1;
      if (r.lat > latency_high[src]) begin
        latency_high[src] = r.lat;
      end
      if (r.lat < latency_low[src]) begin
        latency_low[src] = r.lat;
      end

      // The first frame of a source has nothing to measure a gap against.
      if (!first) begin
        if (seq > previous_seq[src]) begin
          gap = seq - previous_seq[src] - 8'd1;
        end else begin
          gap = 8'd255 + seq - previous_seq[src];
        end
        r.lost = gap;
        missed_frames[src] = missed_frames[src] + {24'd0, gap};
      end
      previous_seq[src] = seq;

      if (rssi_n[src] >= 4'(WINDOW_SAMPLES)) begin
        rssi_acc[src] = {4'd0, rssi};
        rssi_n[src]   = 4'd1;
      end else begin
        rssi_acc[src] = rssi_acc[src] + {4'd0, rssi};
        rssi_n[src]   = rssi_n[src] + 4'd1;
      end
    end

    if (in_table) begin
      r.rcv    = frames_seen[src];
      r.lcnt   = missed_frames[src];
      r.ltot   = latency_acc[src];
      r.lnum   = latency_n[src];
      r.lpeak  = latency_high[src];
      r.lfloor = latency_low[src];
      r.rtot   = rssi_acc[src];
      r.rnum   = rssi_n[src];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, where the block's
  // registered outputs still hold their values from before the edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    link_report_t got;
    link_report_t want;
    if (!rst_ni) begin
      own_filter   = psls_pkg::OWN_ADDR_RESET;
      bcast_filter = psls_pkg::BCAST_ADDR_RESET;
      wipe_records();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          psls_pkg::CFG_OWN_ADDRESS:       own_filter   = cfg_data_i;
          psls_pkg::CFG_BROADCAST_ADDRESS: bcast_filter = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_o && out_ready_i) begin
        got = {accepted_o, frame_latency_o, lost_this_frame_o, received_count_o,
               lost_count_o, latency_total_o, latency_count_o, latency_peak_o,
               latency_floor_o, rssi_total_o, rssi_count_o};
        if (pending_reports.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual %0d",
                   $time, received_count_o);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("accepted", 48'(want.acc), 48'(got.acc));
          check_field("frame_latency", 48'(want.lat), 48'(got.lat));
          check_field("lost_this_frame", 48'(want.lost), 48'(got.lost));
          check_field("received_count", 48'(want.rcv), 48'(got.rcv));
          check_field("lost_count", 48'(want.lcnt), 48'(got.lcnt));
          check_field("latency_total", want.ltot, got.ltot);
          check_field("latency_count", 48'(want.lnum), 48'(got.lnum));
          check_field("latency_peak", 48'(want.lpeak), 48'(got.lpeak));
          check_field("latency_floor", 48'(want.lfloor), 48'(got.lfloor));
          check_field("rssi_total", 48'(want.rtot), 48'(got.rtot));
          check_field("rssi_count", 48'(want.rnum), 48'(got.rnum));
        end
      end

      // Every accepted request yields exactly one result.
      if (in_valid_i && in_ready_o) begin
        want = apply_request(psls_pkg::req_e'(req_type_i), dest_address_i,
                             source_address_i, sequence_index_i, send_time_us_i,
                             arrival_time_us_i, rssi_level_i);
        if (offer_fixed) begin
          want = offer_want;
        end
        pending_reports.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  function automatic link_report_t report(logic acc, logic [19:0] lat, logic [7:0] lost,
                                          logic [31:0] rcv, logic [31:0] lcnt,
                                          logic [47:0] ltot, logic [31:0] lnum,
                                          logic [19:0] lpeak, logic [19:0] lfloor,
                                          logic [11:0] rtot, logic [3:0] rnum);
    return {acc, lat, lost, rcv, lcnt, ltot, lnum, lpeak, lfloor, rtot, rnum};
  endfunction

  function automatic stat_request_t row(psls_pkg::req_e kind, logic [7:0] dest,
                                        logic [7:0] src,
                                        logic [7:0] seq, logic [19:0] sent,
                                        logic [19:0] arrived, logic [7:0] rssi,
                                        bit fixed, link_report_t want);
    stat_request_t r;
    r.kind    = kind;
    r.dest    = dest;
    r.src     = src;
    r.seq     = seq;
    r.sent    = sent;
    r.arrived = arrived;
    r.rssi    = rssi;
    r.fixed   = fixed;
    r.want    = want;
    return r;
  endfunction

  // Offers one request, holds it until the block takes it, then leaves a
  // random gap. With no gap, valid simply stays high for the next request.
  task automatic send_request(input stat_request_t req);
    int unsigned pick;
    int unsigned gap;
    req_type_i        <= req.kind;
    dest_address_i    <= req.dest;
    source_address_i  <= req.src;
    sequence_index_i  <= req.seq;
    send_time_us_i    <= req.sent;
    arrival_time_us_i <= req.arrived;
    rssi_level_i      <= req.rssi;
    in_valid_i        <= 1'b1;
    offer_fixed = req.fixed;
    offer_want  = req.want;
    do begin
      @(posedge clk_i);
    end while (!(in_valid_i && in_ready_o));
    @(negedge clk_i);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      gap = 0;
    end else if (pick < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Drops valid and waits until every result owed has been collected. The
  // pause afterwards covers the pipeline of the block.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Writes the own address register and then the broadcast address register.
  task automatic set_addresses(input logic [7:0] own, input logic [7:0] bcast);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= psls_pkg::CFG_OWN_ADDRESS;
    cfg_data_i  <= own;
    @(negedge clk_i);
    cfg_index_i <= psls_pkg::CFG_BROADCAST_ADDRESS;
    cfg_data_i  <= bcast;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // One phase of random traffic under one address setting. Most requests are
  // frames from a handful of sources with mostly in-order sequence numbers and
  // short latencies; the rest are reads, reserved codes, the odd clear, stray
  // sources, out-of-order numbers and arbitrary or out-of-range times.
  task automatic run_random_phase(input logic [7:0] own, input logic [7:0] bcast,
                                  input bit pressure);
    stat_request_t req;
    int unsigned   pick;
    int unsigned   lag;
    set_addresses(own, bcast);
    if (pressure) begin
      hold_off_req = 1'b1;
    end
    repeat (PHASE_REQUESTS) begin
      pick = $urandom_range(0, 999);
      if (pick < 880) begin
        req.kind = psls_pkg::REQ_FRAME;
      end else if (pick < 950) begin
        req.kind = psls_pkg::REQ_READ;
      end else if (pick < 990) begin
        req.kind = psls_pkg::REQ_RESERVED;
      end else begin
        req.kind = psls_pkg::REQ_CLEAR;
      end

      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        req.src = 8'hFF;
      end else if (pick < 88) begin
        req.src = 8'($urandom_range(0, 5));
      end else begin
        req.src = 8'($urandom);
      end

      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        req.dest = own;
      end else if (pick < 80) begin
        req.dest = bcast;
      end else begin
        req.dest = 8'($urandom);
      end

      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        req.seq = next_seq[req.src];
      end else if (pick < 92) begin
        req.seq = next_seq[req.src] + 8'($urandom_range(1, 6));
      end else begin
        req.seq = 8'($urandom);
      end
      next_seq[req.src] = req.seq + 8'd1;

      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        req.sent = 20'($urandom_range(0, 999999));
        lag = $urandom_range(0, 5000) + req.sent;
        if (lag >= 1000000) begin
          lag = lag - 1000000;
        end
        req.arrived = 20'(lag);
      end else if (pick < 95) begin
        req.sent    = 20'($urandom_range(0, 999999));
        req.arrived = 20'($urandom_range(0, 999999));
      end else begin
        req.sent    = 20'($urandom);
        req.arrived = 20'($urandom);
      end

      req.rssi  = 8'($urandom);
      req.fixed = 1'b0;
      req.want  = '0;
      send_request(req);
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready toggles in random runs. On request it refuses results
  // for a long stretch, so that the block's queue fills and it stops taking
  // requests while the sender keeps offering them.
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned pick;
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        pick = $urandom_range(0, 99);
        if (pick >= 50) begin
          out_ready_i <= 1'b0;
          if (pick < 90) begin
            repeat ($urandom_range(1, 3)) @(negedge clk_i);
          end else begin
            repeat ($urandom_range(10, 40)) @(negedge clk_i);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, a directed table under the reset addresses, then
  // random phases under a range of address settings, extremes included.
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    stat_request_t directed_rows[$];
    link_report_t  blank;
    blank = report(1'b0, 20'd0, 8'd0, 32'd0, 32'd0, 48'd0, 32'd0, 20'd0,
                   FLOOR_AFTER_CLEAR, 12'd0, 4'd0);

    // Reads straight after reset, including the reserved code, see empty records.
    directed_rows.push_back(row(psls_pkg::REQ_READ, 8'd0, 8'd5, 8'd0, 20'd0, 20'd0,
                                8'd0, 1'b1, blank));
    directed_rows.push_back(row(psls_pkg::REQ_RESERVED, 8'd0, 8'd255, 8'd0, 20'd0,
                                20'd0, 8'd0, 1'b1, blank));
    // First frame of a source to the own address: no loss is counted.
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd10, 20'd100,
                                20'd350, 8'd255, 1'b1,
                                report(1'b1, 20'd250, 8'd0, 32'd1, 32'd0, 48'd250,
                                       32'd1, 20'd250, 20'd250, 12'd255, 4'd1)));
    // Broadcast frame arriving across the second boundary, with a repeated
    // sequence number that counts as a full wrap of losses.
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd255, 8'd7, 8'd10, 20'd999999,
                                20'd0, 8'd0, 1'b1,
                                report(1'b1, 20'd1, 8'd255, 32'd2, 32'd255, 48'd251,
                                       32'd2, 20'd250, 20'd1, 12'd255, 4'd2)));
    // Equal send and arrival times mean a latency of one whole second.
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd11, 20'd500,
                                20'd500, 8'd128, 1'b1,
                                report(1'b1, 20'd1000000, 8'd0, 32'd3, 32'd255,
                                       48'd1000251, 32'd3, 20'd1000000, 20'd1,
                                       12'd383, 4'd3)));
    // A frame for another station leaves the record untouched.
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd9, 8'd7, 8'd12, 20'd0, 20'd10,
                                8'd77, 1'b1,
                                report(1'b0, 20'd0, 8'd0, 32'd3, 32'd255,
                                       48'd1000251, 32'd3, 20'd1000000, 20'd1,
                                       12'd383, 4'd3)));
    // Sequence wrapping backwards and forwards, and times at and beyond the
    // end of the second.
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd0, 20'd0,
                                20'd999999, 8'd1, 1'b0, '0));
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd255, 8'd7, 8'd255, 20'hFFFFF,
                                20'hFFFFF, 8'd254, 1'b0, '0));
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd0, 20'd0,
                                20'hFFFFF, 8'd170, 1'b0, '0));
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd1, 20'hFFFFF,
                                20'd0, 8'd85, 1'b0, '0));
    // First frames of the lowest and highest source addresses.
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd255, 8'd0, 8'd200, 20'd10,
                                20'd20, 8'd255, 1'b0, '0));
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd0, 8'd255, 8'd0, 20'd999999,
                                20'd999998, 8'd255, 1'b0, '0));
    // Fill the signal strength window of source 7 and run one sample past it,
    // which restarts the sum.
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd2, 20'd1000,
                                20'd1100, 8'd255, 1'b0, '0));
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd3, 20'd2000,
                                20'd2100, 8'd255, 1'b0, '0));
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd4, 20'd3000,
                                20'd3100, 8'd255, 1'b0, '0));
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd5, 20'd4000,
                                20'd4100, 8'd255, 1'b0, '0));
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd6, 20'd5000,
                                20'd5100, 8'd42, 1'b0, '0));
    directed_rows.push_back(row(psls_pkg::REQ_READ, 8'd0, 8'd7, 8'd0, 20'd0, 20'd0,
                                8'd0, 1'b0, '0));
    // Clear returns the empty record and leaves every record empty.
    directed_rows.push_back(row(psls_pkg::REQ_CLEAR, 8'd0, 8'd7, 8'd0, 20'd0, 20'd0,
                                8'd0, 1'b1, blank));
    directed_rows.push_back(row(psls_pkg::REQ_READ, 8'd0, 8'd7, 8'd0, 20'd0, 20'd0,
                                8'd0, 1'b1, blank));
    directed_rows.push_back(row(psls_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 20'd0, 20'd0,
                                8'd0, 1'b1, blank));
    // After a clear the next frame is again a first frame.
    directed_rows.push_back(row(psls_pkg::REQ_FRAME, 8'd255, 8'd7, 8'd99, 20'd40,
                                20'd30, 8'd9, 1'b0, '0));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i]);
    end
    wait_idle();

    run_random_phase(8'h2A, 8'hFF, 1'b0);
    run_random_phase(8'hFF, 8'h00, 1'b1);
    run_random_phase(8'h00, 8'h00, 1'b0);
    run_random_phase(8'($urandom), 8'($urandom), 1'b0);
    run_random_phase(8'h81, 8'h7E, 1'b0);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_per_source_link_statistics_unit OK");
    end else begin
      $display("tb_per_source_link_statistics_unit NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every gap and
  // every stall at its longest.
  initial begin : watchdog
    #8000000;
    $display("tb_per_source_link_statistics_unit NOT OK");
    $finish;
  end

endmodule
